>>> design/rpve_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpve_pkg: shared constants for the response packet value extractor
// Header tag bytes, fixed byte positions of the response layout and the
// default sizing of the block.
// ----------------------------------------------------------------------------
package rpve_pkg;

  // Default sizing
  localparam int DEF_MAX_PACKET_BYTES = 512;
  localparam int DEF_VALUE_SLOTS      = 3;

  // Number of value ports on the result channel
  localparam int OUT_SLOTS = 3;

  // Response layout
  localparam int HDR_BYTES = 4;  // "RESP"
  localparam int PAD_POS   = 4;  // ignored byte
  localparam int COUNT_POS = 5;  // row count byte
  localparam int ROWS_START = 6; // first row length byte

  localparam logic [7:0] TAG_R = 8'h52;
  localparam logic [7:0] TAG_E = 8'h45;
  localparam logic [7:0] TAG_S = 8'h53;
  localparam logic [7:0] TAG_P = 8'h50;

  // Packet summary handed from the parser to the result stage
  typedef struct packed {
    logic resp;     // header matched and at least four bytes
    logic rewrite;  // response with at least six bytes
  } rpve_flags_t;

  // Expected header byte at a given position
  function automatic logic [7:0] tag_byte(input logic [1:0] idx);
    logic [7:0] t;
    unique case (idx)
      2'd0: t = TAG_R;
      2'd1: t = TAG_E;
      2'd2: t = TAG_S;
      2'd3: t = TAG_P;
      default: t = TAG_R;
    endcase
    return t;
  endfunction

endpackage

>>> design/rpve_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpve_parser: per-byte packet parser
// Tracks byte position, header match, row count and the row walk, and
// collects each row's little-endian first word. Presents the state as it
// stands after the current byte so the result stage can finish the packet.
// ----------------------------------------------------------------------------
module rpve_parser
  import rpve_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES,
  parameter int VALUE_SLOTS      = DEF_VALUE_SLOTS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [7:0]             data_byte,
  input  logic                   packet_end,
  output rpve_flags_t            flags,
  output logic [31:0]            slot_values [VALUE_SLOTS],
  output logic [VALUE_SLOTS-1:0] slot_keep
);

  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int IW = $clog2(VALUE_SLOTS + 1);
  localparam int LW = 10;  // 255 * 4 body bytes

  logic [PW-1:0] byte_position, byte_position_next;
  logic          header_ok, header_ok_next;
  logic [7:0]    row_count, row_count_next;
  logic [IW-1:0] row_index, row_index_next;
  logic [LW-1:0] row_bytes_left, row_bytes_left_next;
  logic [7:0]    row_length, row_length_next;
  logic [31:0]   pending_values [VALUE_SLOTS];
  logic [31:0]   pending_values_next [VALUE_SLOTS];

  // Next state for one byte
  always_comb begin
    logic [LW-1:0] off;
    byte_position_next  = byte_position;
    header_ok_next      = header_ok;
    row_count_next      = row_count;
    row_index_next      = row_index;
    row_bytes_left_next = row_bytes_left;
    row_length_next     = row_length;
    pending_values_next = pending_values;
    off = {row_length, 2'b00} - row_bytes_left;

    if (byte_position < PW'(MAX_PACKET_BYTES)) begin
      byte_position_next = byte_position + PW'(1);
      if (byte_position < PW'(HDR_BYTES)) begin
        if (data_byte != tag_byte(byte_position[1:0])) begin
          header_ok_next = 1'b0;
        end
      end else if (byte_position == PW'(PAD_POS)) begin
        // padding byte, ignored
      end else if (byte_position == PW'(COUNT_POS)) begin
        row_count_next = data_byte;
      end else if ((8'(row_index) < row_count) && (row_index < IW'(VALUE_SLOTS))) begin
        if (row_bytes_left == '0) begin
          // row length byte
          row_length_next     = data_byte;
          row_bytes_left_next = {data_byte, 2'b00};
          for (int s = 0; s < VALUE_SLOTS; s++) begin
            if (row_index == IW'(s)) begin
              pending_values_next[s] = '0;
            end
          end
          if (data_byte == 8'd0) begin
            row_index_next = row_index + IW'(1);
          end
        end else begin
          // row body byte; first four go into the value
          if (off < LW'(4)) begin
            for (int s = 0; s < VALUE_SLOTS; s++) begin
              if (row_index == IW'(s)) begin
                pending_values_next[s] = pending_values[s]
                                       | (32'(data_byte) << {off[1:0], 3'b000});
              end
            end
          end
          row_bytes_left_next = row_bytes_left - LW'(1);
          if (row_bytes_left == LW'(1)) begin
            row_index_next = row_index + IW'(1);
          end
        end
      end
    end
  end

  // Packet summary after this byte
  always_comb begin
    flags.resp    = header_ok_next && (byte_position_next >= PW'(HDR_BYTES));
    flags.rewrite = flags.resp && (byte_position_next >= PW'(ROWS_START));
    slot_values   = pending_values_next;
    for (int s = 0; s < VALUE_SLOTS; s++) begin
      slot_keep[s] = IW'(s) < row_index_next;
    end
  end

  // Parser state; cleared at reset and after each packet end
  always_ff @(posedge clk) begin
    if (rst || (take && packet_end)) begin
      byte_position  <= '0;
      header_ok      <= 1'b1;
      row_count      <= '0;
      row_index      <= '0;
      row_bytes_left <= '0;
      row_length     <= '0;
      for (int s = 0; s < VALUE_SLOTS; s++) begin
        pending_values[s] <= '0;
      end
    end else if (take) begin
      byte_position  <= byte_position_next;
      header_ok      <= header_ok_next;
      row_count      <= row_count_next;
      row_index      <= row_index_next;
      row_bytes_left <= row_bytes_left_next;
      row_length     <= row_length_next;
      pending_values <= pending_values_next;
    end
  end

endmodule

>>> design/rpve_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpve_result: held values, response counter and result register
// At each packet end updates the held values and the response count and
// loads one result request into the output register.
// ----------------------------------------------------------------------------
module rpve_result
  import rpve_pkg::*;
#(
  parameter int VALUE_SLOTS = DEF_VALUE_SLOTS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  rpve_flags_t            flags,
  input  logic [31:0]            slot_values [VALUE_SLOTS],
  input  logic [VALUE_SLOTS-1:0] slot_keep,
  input  logic                   result_stall,
  output logic                   result_valid,
  output logic [31:0]            value_x_bits,
  output logic [31:0]            value_y_bits,
  output logic [31:0]            value_z_bits,
  output logic                   was_response,
  output logic                   values_rewritten,
  output logic [31:0]            response_total
);

  logic [31:0] held_values [VALUE_SLOTS];
  logic [31:0] held_values_next [VALUE_SLOTS];
  logic [31:0] response_counter, response_counter_next;
  logic [31:0] out_values [OUT_SLOTS];

  // Held value and counter update at packet end
  always_comb begin
    held_values_next      = held_values;
    response_counter_next = response_counter + 32'(flags.resp);
    if (flags.rewrite) begin
      for (int s = 0; s < VALUE_SLOTS; s++) begin
        held_values_next[s] = slot_keep[s] ? slot_values[s] : 32'd0;
      end
    end
  end

  // Map slots onto the value ports; missing slots read as zero
  for (genvar o = 0; o < OUT_SLOTS; o++) begin : g_out
    if (o < VALUE_SLOTS) begin : g_slot
      assign out_values[o] = held_values_next[o];
    end else begin : g_zero
      assign out_values[o] = 32'd0;
    end
  end

  // Held state
  always_ff @(posedge clk) begin
    if (rst) begin
      response_counter <= '0;
      for (int s = 0; s < VALUE_SLOTS; s++) begin
        held_values[s] <= '0;
      end
    end else if (load) begin
      response_counter <= response_counter_next;
      held_values      <= held_values_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_x_bits     <= out_values[0];
      value_y_bits     <= out_values[1];
      value_z_bits     <= out_values[2];
      was_response     <= flags.resp;
      values_rewritten <= flags.rewrite;
      response_total   <= response_counter_next;
    end
  end

endmodule

>>> design/response_packet_value_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// response_packet_value_extractor: pulls three 32-bit values out of
// response packets received one byte per request
//
// Byte channel: byte_valid / byte_stall carry data_byte and packet_end; a
// request moves at an edge with byte_valid high and byte_stall low.
// Result channel: result_valid / result_stall carry the three held values,
// was_response, values_rewritten and response_total; one result request is
// produced for each byte with packet_end set, none for other bytes.
// Throughput: one byte per cycle while no packet-end byte is held back. Every
// byte passes an input register and is parsed from there; a packet's result
// is registered when its last byte leaves the input register.
// When the receiver stalls, the result register holds its request. Bytes
// without packet_end keep flowing; a packet-end byte waits in the input
// register until the result register is free; byte_stall is high meanwhile.
// Reset clears the parser, the held values, the response counter and both
// valid flags; the block accepts bytes as soon as reset is released.
// ----------------------------------------------------------------------------
module response_packet_value_extractor
  import rpve_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES,
  parameter int VALUE_SLOTS      = DEF_VALUE_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        packet_end,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] value_x_bits,
  output logic [31:0] value_y_bits,
  output logic [31:0] value_z_bits,
  output logic        was_response,
  output logic        values_rewritten,
  output logic [31:0] response_total
);

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   in_end;
  logic                   take;
  logic                   out_free;
  rpve_flags_t            flags;
  logic [31:0]            slot_values [VALUE_SLOTS];
  logic [VALUE_SLOTS-1:0] slot_keep;

  // Byte is consumed unless it ends a packet and the result register is busy
  assign out_free   = !result_valid || !result_stall;
  assign take       = in_valid && (!in_end || out_free);
  assign byte_stall = in_valid && !take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!byte_stall) begin
      in_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_byte <= data_byte;
      in_end  <= packet_end;
    end
  end

  rpve_parser #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
    .VALUE_SLOTS      (VALUE_SLOTS)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (in_byte),
    .packet_end  (in_end),
    .flags       (flags),
    .slot_values (slot_values),
    .slot_keep   (slot_keep)
  );

  rpve_result #(
    .VALUE_SLOTS (VALUE_SLOTS)
  ) u_result (
    .clk              (clk),
    .rst              (rst),
    .load             (take && in_end),
    .flags            (flags),
    .slot_values      (slot_values),
    .slot_keep        (slot_keep),
    .result_stall     (result_stall),
    .result_valid     (result_valid),
    .value_x_bits     (value_x_bits),
    .value_y_bits     (value_y_bits),
    .value_z_bits     (value_z_bits),
    .was_response     (was_response),
    .values_rewritten (values_rewritten),
    .response_total   (response_total)
  );

endmodule

>>> design/rpve_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpve_checker: port-level checks for the response packet value extractor
// Watches the top-level ports only; attached by the bind at the end.
// ----------------------------------------------------------------------------
module rpve_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic        was_response,
  input logic        values_rewritten,
  input logic [31:0] response_total
);

  // A stalled result stays
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result request dropped while stalled");

  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(response_total))
    else $error("response_total changed while stalled");

  // Values are only rewritten for a response
  a_rewrite_resp: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!values_rewritten || was_response))
    else $error("values rewritten for a non-response packet");

  // Bytes are only held back by a stalled, full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (result_valid && result_stall))
    else $error("byte stall without a stalled result");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind response_packet_value_extractor rpve_checker u_rpve_checker (
  .clk              (clk),
  .rst              (rst),
  .byte_stall       (byte_stall),
  .result_valid     (result_valid),
  .result_stall     (result_stall),
  .was_response     (was_response),
  .values_rewritten (values_rewritten),
  .response_total   (response_total)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: response packet value extractor
// Feeds response packets byte by byte. A short fixed table comes first, then
// random packets: mostly well-formed responses, with short, broken and noise
// packets and one oversize packet mixed in. The sender gap and receiver
// stall rates change from phase to phase. A local predictor tracks the packet
// parser and the held values, and each result is checked field by field
// against the oldest predicted packet summary.
// ----------------------------------------------------------------------------
module testbench;
  import rpve_pkg::*;

  localparam int PKT_LIMIT    = DEF_MAX_PACKET_BYTES;
  localparam int SLOTS        = DEF_VALUE_SLOTS;
  localparam int PHASE_BYTES  = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_GAP      = 60;
  localparam int CYCLE_LIMIT  = 300000;
  localparam logic [3:0][7:0] RESP_TAG = {TAG_P, TAG_S, TAG_E, TAG_R};

  typedef struct packed {
    logic [31:0] x_bits;
    logic [31:0] y_bits;
    logic [31:0] z_bits;
    logic        resp;
    logic        rewrite;
    logic [31:0] total;
  } packet_summary_t;

  typedef struct packed {
    logic [7:0]      b;
    logic            last;
    logic            typed;
    packet_summary_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  data_byte;
  logic        packet_end;
  logic        result_valid;
  logic        result_stall;
  logic [31:0] value_x_bits;
  logic [31:0] value_y_bits;
  logic [31:0] value_z_bits;
  logic        was_response;
  logic        values_rewritten;
  logic [31:0] response_total;

  // Predicted results, oldest first
  packet_summary_t pending_summaries[$];
  stim_row_t       directed_rows[$];
  logic [7:0]      pkt_bytes[$];

  int mismatches      = 0;
  int bytes_sent      = 0;
  int packets_sent    = 0;
  int results_checked = 0;
  int cycle_count     = 0;
  int gap_pct         = 0;
  int stall_pct       = 0;
  int hold_requests   = 0;
  int holds_served    = 0;
  int hold_left       = 0;
  packet_summary_t seen_result;
  packet_summary_t oldest_summary;

  // Parser state of the predictor
  logic [9:0]  pos;
  logic        hdr_ok;
  logic [7:0]  rows_expected;
  logic [1:0]  rows_done;
  logic [9:0]  body_left;
  logic [7:0]  body_len;
  logic [31:0] partial_vals[SLOTS];
  logic [31:0] held_vals[SLOTS];
  logic [31:0] resp_count;

  response_packet_value_extractor u_top (
    .clk              (clk),
    .rst              (rst),
    .byte_valid       (byte_valid),
    .byte_stall       (byte_stall),
    .data_byte        (data_byte),
    .packet_end       (packet_end),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .value_x_bits     (value_x_bits),
    .value_y_bits     (value_y_bits),
    .value_z_bits     (value_z_bits),
    .was_response     (was_response),
    .values_rewritten (values_rewritten),
    .response_total   (response_total)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Per-packet state back to its idle values
  function automatic void clear_parser();
    pos = '0;
    hdr_ok = 1'b1;
    rows_expected = '0;
    rows_done = '0;
    body_left = '0;
    body_len = '0;
    for (int i = 0; i < SLOTS; i++) partial_vals[i] = '0;
  endfunction

  // Absorb one byte; returns 1 with the packet summary on a packet end
  function automatic bit extract_byte(input logic [7:0] b, input logic last,
                                      output packet_summary_t s);
    int p;
    int off;
    logic [31:0] slot_vals[3];
    s = '0;
    p = int'(pos);
    if (p < PKT_LIMIT) begin
      pos = pos + 10'd1;
      if (p < HDR_BYTES) begin
        if (b != RESP_TAG[p]) hdr_ok = 1'b0;
      end else if (p == COUNT_POS) begin
        rows_expected = b;
      end else if (p > COUNT_POS && rows_done < rows_expected && rows_done < SLOTS) begin
        if (body_left == 0) begin
          // length byte opens a row
          body_len = b;
          body_left = 10'(b) * 10'd4;
          partial_vals[rows_done] = '0;
          if (b == 8'd0) rows_done = rows_done + 2'd1;
        end else begin
          // body byte; only the first four bytes form the value
          off = int'(body_len) * 4 - int'(body_left);
          if (off < 4) partial_vals[rows_done] |= 32'(b) << (8 * off);
          body_left = body_left - 10'd1;
          if (body_left == 0) rows_done = rows_done + 2'd1;
        end
      end
    end
    if (!last) return 1'b0;

    s.resp = hdr_ok && pos >= HDR_BYTES;
    s.rewrite = s.resp && pos >= ROWS_START;
    if (s.resp) resp_count = resp_count + 32'd1;
    if (s.rewrite) begin
      for (int i = 0; i < SLOTS; i++) held_vals[i] = (i < rows_done) ? partial_vals[i] : '0;
    end
    for (int i = 0; i < 3; i++) slot_vals[i] = (i < SLOTS) ? held_vals[i] : '0;
    s.x_bits = slot_vals[0];
    s.y_bits = slot_vals[1];
    s.z_bits = slot_vals[2];
    s.total = resp_count;
    clear_parser();
    return 1'b1;
  endfunction

  // Offer one byte after a random gap; predict once it is taken
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input packet_summary_t want);
    int idle;
    packet_summary_t s;
    idle = 0;
    while (idle < MAX_GAP && $urandom_range(99) < gap_pct) idle++;
    if (idle > 0) begin
      byte_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= b;
    packet_end <= last;
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
    if (extract_byte(b, last, s)) begin
      packets_sent++;
      pending_summaries.push_back(typed ? want : s);
    end
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++)
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, 1'b0, '0);
  endtask

  // Sender goes quiet until every predicted result has arrived
  task automatic drain_results();
    byte_valid <= 1'b0;
    do @(posedge clk); while (pending_summaries.size() != 0);
  endtask

  // Random packet into pkt_bytes; oversize forces one past the byte limit
  task automatic build_packet(input bit oversize);
    int kind;
    int count;
    int rows;
    int len;
    int cut;
    pkt_bytes.delete();
    kind = oversize ? 0 : $urandom_range(99);
    if (kind < 70) begin
      // response layout with random rows; a few get a damaged header
      for (int i = 0; i < HDR_BYTES; i++) pkt_bytes.push_back(RESP_TAG[i]);
      pkt_bytes.push_back(8'($urandom));
      if (oversize) count = 3;
      else if ($urandom_range(99) < 70) count = $urandom_range(0, 4);
      else if ($urandom_range(99) < 70) count = $urandom_range(5, 8);
      else count = $urandom_range(0, 255);
      pkt_bytes.push_back(8'(count));
      rows = (count < SLOTS + 1) ? count : SLOTS + 1;
      for (int r = 0; r < rows; r++) begin
        if (oversize) len = (r == 0) ? $urandom_range(100, 110) :
                            (r == 1) ? $urandom_range(20, 30) : $urandom_range(1, 40);
        else if ($urandom_range(99) < 15) len = 0;
        else if ($urandom_range(99) < 82) len = $urandom_range(1, 3);
        else len = $urandom_range(4, 20);
        pkt_bytes.push_back(8'(len));
        repeat (4 * len) pkt_bytes.push_back(8'($urandom));
      end
      if (oversize) begin
        cut = PKT_LIMIT + $urandom_range(1, 28);
        while (pkt_bytes.size() < cut) pkt_bytes.push_back(8'($urandom));
        while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      end else if ($urandom_range(3) == 0) begin
        // cut short, so later rows do not fit
        cut = $urandom_range(ROWS_START, pkt_bytes.size());
        while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      end else if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom));
      end
      if (kind >= 60) pkt_bytes[$urandom_range(3)] ^= 8'h01 << $urandom_range(7);
    end else if (kind < 78) begin
      // short response: header with or without the padding byte
      for (int i = 0; i < HDR_BYTES; i++) pkt_bytes.push_back(RESP_TAG[i]);
      if ($urandom_range(1) == 1) pkt_bytes.push_back(8'($urandom));
    end else if (kind < 86) begin
      // header prefix too short to count
      cut = $urandom_range(1, 3);
      for (int i = 0; i < cut; i++) pkt_bytes.push_back(RESP_TAG[i]);
    end else begin
      repeat ($urandom_range(1, 16)) pkt_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: check taken results, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      seen_result = {value_x_bits, value_y_bits, value_z_bits, was_response,
                     values_rewritten, response_total};
      if (pending_summaries.size() == 0) begin
        $display("%0t: result with no packet pending, expected none, got %h",
                 $time, seen_result);
        mismatches++;
      end else begin
        oldest_summary = pending_summaries.pop_front();
        results_checked++;
        check_field("value_x_bits", oldest_summary.x_bits, seen_result.x_bits);
        check_field("value_y_bits", oldest_summary.y_bits, seen_result.y_bits);
        check_field("value_z_bits", oldest_summary.z_bits, seen_result.z_bits);
        check_field("was_response", 32'(oldest_summary.resp), 32'(seen_result.resp));
        check_field("values_rewritten", 32'(oldest_summary.rewrite),
                    32'(seen_result.rewrite));
        check_field("response_total", oldest_summary.total, seen_result.total);
      end
    end
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Directed table entry
  task automatic add_row(input logic [7:0] b, input logic last, input logic typed,
                         input packet_summary_t want);
    directed_rows.push_back('{b: b, last: last, typed: typed, want: want});
  endtask

  initial begin
    int phase_start;
    rst <= 1'b1;
    byte_valid <= 1'b0;
    data_byte <= '0;
    packet_end <= 1'b0;
    result_stall <= 1'b0;
    resp_count = '0;
    for (int i = 0; i < SLOTS; i++) held_vals[i] = '0;
    clear_parser();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // one-byte non-response right after reset
    add_row(8'hFF, 1'b1, 1'b1, {32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'd0});
    // short response: counted, values kept
    add_row(TAG_R, 1'b0, 1'b0, '0);
    add_row(TAG_E, 1'b0, 1'b0, '0);
    add_row(TAG_S, 1'b0, 1'b0, '0);
    add_row(TAG_P, 1'b1, 1'b1, {32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 32'd1});
    // response with no rows: everything rewritten to zero
    add_row(TAG_R, 1'b0, 1'b0, '0);
    add_row(TAG_E, 1'b0, 1'b0, '0);
    add_row(TAG_S, 1'b0, 1'b0, '0);
    add_row(TAG_P, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1, {32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 32'd2});
    // one full row, a zero-length row, then a row cut off by the packet end
    add_row(TAG_R, 1'b0, 1'b0, '0);
    add_row(TAG_E, 1'b0, 1'b0, '0);
    add_row(TAG_S, 1'b0, 1'b0, '0);
    add_row(TAG_P, 1'b0, 1'b0, '0);
    add_row(8'hAA, 1'b0, 1'b0, '0);
    add_row(8'h03, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(8'hDE, 1'b0, 1'b0, '0);
    add_row(8'hAD, 1'b0, 1'b0, '0);
    add_row(8'hBE, 1'b0, 1'b0, '0);
    add_row(8'hEF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h02, 1'b0, 1'b0, '0);
    add_row(8'h11, 1'b1, 1'b0, '0);
    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].want);
    drain_results();

    // random phases: none, sender gaps, receiver stalls, both light
    for (int phase = 0; phase < 4; phase++) begin
      gap_pct = (phase == 1) ? 84 : (phase == 3) ? 14 : 0;
      stall_pct <= (phase == 2) ? 84 : (phase == 3) ? 14 : 0;
      if (phase == 0) begin
        // packet past the byte limit, then a long receiver hold-off
        build_packet(1'b1);
        send_packet();
        hold_requests <= hold_requests + 1;
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_packet(1'b0);
        send_packet();
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d bytes in %0d packets, %0d results checked", bytes_sent,
             packets_sent, results_checked);
    $display("Covered short, broken, noise, cut-off and oversize packets under stalls");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
